// ----- sv/hbp_pkg.sv -----
// Shared types, codes and helpers of the HPACK header block parser.
package hbp_pkg;

    localparam int STATIC_ENTRIES = 61;
    localparam int Q_DEPTH        = 4;
    localparam logic [7:0] MAX_PAIRS_RESET = 8'd16;

    localparam logic [2:0] KIND_STATIC_PAIR = 3'd0;
    localparam logic [2:0] KIND_TABLE_NAME  = 3'd1;
    localparam logic [2:0] KIND_NAME_BYTE   = 3'd2;
    localparam logic [2:0] KIND_VALUE_BYTE  = 3'd3;
    localparam logic [2:0] KIND_PAIR_END    = 3'd4;
    localparam logic [2:0] KIND_BLOCK_DONE  = 3'd5;
    localparam logic [2:0] KIND_ERROR       = 3'd6;

    localparam logic [2:0] ERR_TRUNCATED = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_HUFFMAN   = 3'd2;
    localparam logic [2:0] ERR_BAD_NAME  = 3'd3;
    localparam logic [2:0] ERR_TOO_MANY  = 3'd4;
    localparam logic [2:0] ERR_NONE      = 3'd0;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_IDX_CONT,
        PH_NIDX_CONT,
        PH_NLEN_FIRST,
        PH_NLEN_CONT,
        PH_NAME,
        PH_VLEN_FIRST,
        PH_VLEN_CONT,
        PH_VALUE
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] table_index;
        logic [7:0] text_byte;
        logic [7:0] pair_total;
        logic [2:0] error_code;
    } t_result;

    // Up to three results caused by one input byte.
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_q_push;

    function automatic t_result hbp_make(input logic [2:0] kind, input logic [5:0] idx,
                                         input logic [7:0] text, input logic [7:0] pairs,
                                         input logic [2:0] code);
        t_result r;
        r.kind        = kind;
        r.table_index = idx;
        r.text_byte   = text;
        r.pair_total  = pairs;
        r.error_code  = code;
        return r;
    endfunction

endpackage

// ----- sv/hbp_front.sv -----
// Front part: takes header block bytes, runs the field parser, forms result bundles.
module hbp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_block_end,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    output hbp_pkg::t_q_push o_push
);
    import hbp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [6:0]  r_shift, n_shift;
    logic [63:0] r_left, n_left;
    logic [7:0]  r_pairs, n_pairs;
    logic        r_discard, n_discard;
    logic [7:0]  r_max_pairs;

    t_bundle     bund;
    logic [1:0]  cnt;
    logic        failed;
    logic        fin;
    t_phase      which;
    logic [63:0] val;
    logic        do_pair_end;
    logic [63:0] sum;
    logic [6:0]  shift_next;

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_shift     = r_shift;
        n_left      = r_left;
        n_pairs     = r_pairs;
        n_discard   = r_discard;
        bund        = '0;
        cnt         = 2'd0;
        failed      = 1'b0;
        fin         = 1'b0;
        which       = PH_IDX_CONT;
        val         = '0;
        do_pair_end = 1'b0;
        sum         = r_acc + ({57'd0, i_data_byte[6:0]} << r_shift[5:0]);
        shift_next  = r_shift + 7'd7;

        if (i_accept && r_discard) begin
            if (i_block_end) begin
                n_phase   = PH_IDLE;
                n_acc     = '0;
                n_shift   = '0;
                n_left    = '0;
                n_pairs   = '0;
                n_discard = 1'b0;
            end
        end else if (i_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_data_byte[7]) begin
                        if (i_data_byte[6:0] != 7'h7F) begin
                            fin   = 1'b1;
                            which = PH_IDX_CONT;
                            val   = {57'd0, i_data_byte[6:0]};
                        end else begin
                            n_acc   = 64'h7F;
                            n_shift = '0;
                            n_phase = PH_IDX_CONT;
                        end
                    end else begin
                        if (i_data_byte[5:0] != 6'h3F) begin
                            fin   = 1'b1;
                            which = PH_NIDX_CONT;
                            val   = {58'd0, i_data_byte[5:0]};
                        end else begin
                            n_acc   = 64'h3F;
                            n_shift = '0;
                            n_phase = PH_NIDX_CONT;
                        end
                    end
                end
                PH_NLEN_FIRST, PH_VLEN_FIRST: begin
                    if (i_data_byte[7]) begin
                        bund.res[cnt] = hbp_make(KIND_ERROR, 6'd0, 8'd0, n_pairs, ERR_HUFFMAN);
                        cnt     = cnt + 2'd1;
                        failed  = 1'b1;
                        n_phase = PH_IDLE;
                    end else if (i_data_byte[6:0] != 7'h7F) begin
                        fin   = 1'b1;
                        which = (r_phase == PH_NLEN_FIRST) ? PH_NLEN_CONT : PH_VLEN_CONT;
                        val   = {57'd0, i_data_byte[6:0]};
                    end else begin
                        n_acc   = 64'h7F;
                        n_shift = '0;
                        n_phase = (r_phase == PH_NLEN_FIRST) ? PH_NLEN_CONT : PH_VLEN_CONT;
                    end
                end
                PH_NAME: begin
                    bund.res[cnt] = hbp_make(KIND_NAME_BYTE, 6'd0, i_data_byte, n_pairs,
                                             ERR_NONE);
                    cnt    = cnt + 2'd1;
                    n_left = r_left - 64'd1;
                    if (r_left == 64'd1) begin
                        n_phase = PH_VLEN_FIRST;
                    end
                end
                PH_VALUE: begin
                    bund.res[cnt] = hbp_make(KIND_VALUE_BYTE, 6'd0, i_data_byte, n_pairs,
                                             ERR_NONE);
                    cnt    = cnt + 2'd1;
                    n_left = r_left - 64'd1;
                    if (r_left == 64'd1) begin
                        do_pair_end = 1'b1;
                    end
                end
                PH_IDX_CONT, PH_NIDX_CONT, PH_NLEN_CONT, PH_VLEN_CONT: begin
                    n_acc   = sum;
                    n_shift = shift_next;
                    if (!i_data_byte[7]) begin
                        fin   = 1'b1;
                        which = r_phase;
                        val   = sum;
                    end else if (shift_next > 7'd63) begin
                        bund.res[cnt] = hbp_make(KIND_ERROR, 6'd0, 8'd0, n_pairs, ERR_OVERFLOW);
                        cnt     = cnt + 2'd1;
                        failed  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // A prefix integer has just completed.
            if (fin) begin
                case (which)
                    PH_IDX_CONT: begin
                        n_phase = PH_IDLE;
                        if (val >= 64'd1 && val <= 64'(STATIC_ENTRIES)) begin
                            if (n_pairs >= r_max_pairs) begin
                                bund.res[cnt] = hbp_make(KIND_ERROR, 6'd0, 8'd0, n_pairs,
                                                         ERR_TOO_MANY);
                                cnt    = cnt + 2'd1;
                                failed = 1'b1;
                            end else begin
                                n_pairs = n_pairs + 8'd1;
                                bund.res[cnt] = hbp_make(KIND_STATIC_PAIR, val[5:0], 8'd0,
                                                         n_pairs, ERR_NONE);
                                cnt = cnt + 2'd1;
                            end
                        end
                    end
                    PH_NIDX_CONT: begin
                        if (val == 64'd0) begin
                            n_phase = PH_NLEN_FIRST;
                        end else if (val <= 64'(STATIC_ENTRIES)) begin
                            bund.res[cnt] = hbp_make(KIND_TABLE_NAME, val[5:0], 8'd0, n_pairs,
                                                     ERR_NONE);
                            cnt     = cnt + 2'd1;
                            n_phase = PH_VLEN_FIRST;
                        end else begin
                            bund.res[cnt] = hbp_make(KIND_ERROR, 6'd0, 8'd0, n_pairs,
                                                     ERR_BAD_NAME);
                            cnt     = cnt + 2'd1;
                            failed  = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_NLEN_CONT: begin
                        if (val == 64'd0) begin
                            n_phase = PH_VLEN_FIRST;
                        end else begin
                            n_left  = val;
                            n_phase = PH_NAME;
                        end
                    end
                    default: begin
                        if (val == 64'd0) begin
                            do_pair_end = 1'b1;
                        end else begin
                            n_left  = val;
                            n_phase = PH_VALUE;
                        end
                    end
                endcase
            end

            if (do_pair_end) begin
                n_phase = PH_IDLE;
                if (n_pairs >= r_max_pairs) begin
                    bund.res[cnt] = hbp_make(KIND_ERROR, 6'd0, 8'd0, n_pairs, ERR_TOO_MANY);
                    cnt    = cnt + 2'd1;
                    failed = 1'b1;
                end else begin
                    n_pairs = n_pairs + 8'd1;
                    bund.res[cnt] = hbp_make(KIND_PAIR_END, 6'd0, 8'd0, n_pairs, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
            end

            if (i_block_end) begin
                if (!failed) begin
                    if (n_phase != PH_IDLE) begin
                        bund.res[cnt] = hbp_make(KIND_ERROR, 6'd0, 8'd0, n_pairs,
                                                 ERR_TRUNCATED);
                    end else begin
                        bund.res[cnt] = hbp_make(KIND_BLOCK_DONE, 6'd0, 8'd0, n_pairs,
                                                 ERR_NONE);
                    end
                    cnt = cnt + 2'd1;
                end
                n_phase   = PH_IDLE;
                n_acc     = '0;
                n_shift   = '0;
                n_left    = '0;
                n_pairs   = '0;
                n_discard = 1'b0;
            end else if (failed) begin
                n_discard = 1'b1;
                n_phase   = PH_IDLE;
            end
        end

        bund.cnt          = cnt;
        o_push.valid      = i_accept && (cnt != 2'd0);
        o_push.bundle     = bund;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_pairs     <= '0;
            r_discard   <= 1'b0;
            r_max_pairs <= MAX_PAIRS_RESET;
        end else begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_shift   <= n_shift;
            r_left    <= n_left;
            r_pairs   <= n_pairs;
            r_discard <= n_discard;
            if (i_cfg_wr_en) begin
                r_max_pairs <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ----- sv/hbp_queue.sv -----
// Short queue of result bundles between the front and back parts.
module hbp_queue #(
    parameter int DEPTH = hbp_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hbp_pkg::t_q_push i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output hbp_pkg::t_bundle o_head
);
    import hbp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.bundle;
        end
    end

endmodule

// ----- sv/hbp_back.sv -----
// Back part: unpacks queued bundles into single result beats in an output register.
module hbp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  hbp_pkg::t_bundle i_head,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [2:0]       o_kind,
    output logic [5:0]       o_table_index,
    output logic [7:0]       o_text_byte,
    output logic [7:0]       o_pair_total,
    output logic [2:0]       o_error_code,
    output logic             o_last
);
    import hbp_pkg::*;

    logic       r_valid;
    logic [1:0] r_pos, n_pos;
    logic       load;
    logic       take;
    logic       is_last;
    t_result    cur;

    assign load    = !r_valid || !i_stall;
    assign take    = load && i_head_valid;
    assign cur     = i_head.res[r_pos];
    assign is_last = (r_pos == (i_head.cnt - 2'd1));
    assign o_pop   = take && is_last;
    assign o_valid = r_valid;

    always_comb begin
        n_pos = r_pos;
        if (o_pop) begin
            n_pos = 2'd0;
        end else if (take) begin
            n_pos = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else begin
            r_pos <= n_pos;
            if (load) begin
                r_valid <= i_head_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_kind        <= cur.kind;
            o_table_index <= cur.table_index;
            o_text_byte   <= cur.text_byte;
            o_pair_total  <= cur.pair_total;
            o_error_code  <= cur.error_code;
            o_last        <= is_last;
        end
    end

endmodule

// ----- sv/hpack_header_block_parser_top.sv -----
// Top level of the HPACK header block parser (static table only).
//
//  Channel  | Valid    | Stall    | Payload
//  ---------+----------+----------+--------------------------------------------------
//  input    | i_valid  | o_stall  | i_data_byte, i_block_end
//  output   | o_valid  | i_stall  | o_kind, o_table_index, o_text_byte, o_pair_total,
//           |          |          | o_error_code, o_last
//  config   | i_cfg_wr_en (no stall) | i_cfg_wr_data (max_pair_count)
//
// The front part parses one byte per cycle and hands the zero to three results that
// the byte causes, as one bundle, to a four-entry queue.  The back part turns each
// bundle into result beats, one per cycle while i_stall is low, through a registered
// output stage; bytes giving no result never touch the queue.  Input bytes are held
// off (o_stall) only while the queue is full.  Reset is synchronous and active low:
// it empties the queue, clears the parse state and sets max_pair_count to sixteen.
module hpack_header_block_parser_top #(
    parameter int QUEUE_DEPTH = hbp_pkg::Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_block_end,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [5:0] o_table_index,
    output logic [7:0] o_text_byte,
    output logic [7:0] o_pair_total,
    output logic [2:0] o_error_code,
    output logic       o_last
);
    import hbp_pkg::*;

    t_q_push q_push;
    t_bundle q_head;
    logic    q_full;
    logic    q_head_valid;
    logic    q_pop;
    logic    in_accept;

    // A byte is accepted whenever the queue has room for whatever it may produce.
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    hbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_block_end   (i_block_end),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (q_push)
    );

    hbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // The back part retires a bundle as its final beat is loaded into the output register.
    hbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_head_valid),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_table_index (o_table_index),
        .o_text_byte   (o_text_byte),
        .o_pair_total  (o_pair_total),
        .o_error_code  (o_error_code),
        .o_last        (o_last)
    );

endmodule
